// ===== rtl/ptpe_pkg.sv =====
// Package for the prefix triggered path extractor.
// Holds payload types, register and phase codes, and the URL character test.
// No dependencies; every other file of the block imports it.
package ptpe_pkg;

    // Default for the longest prefix that the block compares.
    localparam int PREFIX_MAX_DEFAULT = 32;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LENGTH_W    = 6;
    localparam int WORD_BYTES  = 8;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_WORD0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_WORD1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_WORD2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_WORD3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LENGTH = 3'd4;

    // Scanner phase codes.
    localparam logic [1:0] PH_MATCH   = 2'd0;
    localparam logic [1:0] PH_FIRST   = 2'd1;
    localparam logic [1:0] PH_CAPTURE = 2'd2;

    // Captured byte count, saturating at two.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       path_last;
    } out_item_t;

    // Result of one scanner step.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_result_t;

    // True for a letter, a digit, or one of / . _ -
    function automatic logic url_char(input logic [7:0] b);
        logic is_lower;
        logic is_upper;
        logic is_digit;
        logic is_punct;
        is_lower = (b >= 8'h61) && (b <= 8'h7a);
        is_upper = (b >= 8'h41) && (b <= 8'h5a);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
        is_punct = (b == 8'h2f) || (b == 8'h2e) || (b == 8'h5f) || (b == 8'h2d);
        return is_lower || is_upper || is_digit || is_punct;
    endfunction

endpackage

// ===== rtl/prefix_triggered_path_extractor_unit.sv =====
// Top level of the prefix triggered path extractor.
// Input register, scanner, result register and configuration registers.
// Depends on ptpe_pkg, ptpe_cfg_regs and ptpe_scanner.
//
//   channel   direction  handshake                 word
//   in        input      in_valid / in_ready       in_data (in_byte, end_of_stream)
//   out       output     out_valid / out_ready     out_data (path_byte, path_last)
//   cfg       input      cfg_write_en              cfg_index, cfg_data
//
// One word is accepted per cycle unless the output stalls; a word's result, if any,
// is registered in the result register. The rate is set by the single scanner state
// update between the input and result registers. Reset clears the pipeline, the
// scanner and the registers. A stalled output holds its word while the input
// register keeps one more word, so input stalls only when both stages are full.
module prefix_triggered_path_extractor_unit
    import ptpe_pkg::*;
#(
    parameter int MAX_PREFIX = PREFIX_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                s1_valid_reg;
    in_item_t            s1_item_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;
    logic                s1_adv;
    step_result_t        result;
    logic [7:0]          prefix_bytes [MAX_PREFIX];
    logic [LENGTH_W-1:0] eff_length;

    ptpe_cfg_regs #(
        .MAX_PREFIX(MAX_PREFIX)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .prefix_bytes (prefix_bytes),
        .eff_length   (eff_length)
    );

    ptpe_scanner #(
        .MAX_PREFIX(MAX_PREFIX)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_adv),
        .item         (s1_item_reg),
        .prefix_bytes (prefix_bytes),
        .eff_length   (eff_length),
        .result       (result)
    );

    // The input stage moves on when the result register is free or draining.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= result.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && result.valid)
        begin
            out_item_reg <= result.item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // A word waiting in the input stage is kept until the scanner takes it.
    a_s1_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg && $stable(s1_item_reg)
    ) else $error("input stage lost a word");

    // A result word is never overwritten before it is taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !s1_adv
    ) else $error("result register overwritten while stalled");

endmodule

// ===== rtl/ptpe_cfg_regs.sv =====
// Configuration registers of the path extractor: prefix bytes and length.
// Produces the prefix byte array and the clamped prefix length.
// Depends on ptpe_pkg.
module ptpe_cfg_regs
    import ptpe_pkg::*;
#(
    parameter int MAX_PREFIX = PREFIX_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [7:0]             prefix_bytes [MAX_PREFIX],
    output logic [LENGTH_W-1:0]    eff_length
);

    logic [7:0]          prefix_bytes_reg [MAX_PREFIX];
    logic [LENGTH_W-1:0] prefix_length_reg;

    // Each prefix byte lives in a fixed lane of one of the word registers.
    for (genvar g = 0; g < MAX_PREFIX; g++)
    begin : g_byte
        localparam int WORD_SEL = g / WORD_BYTES;
        localparam int BYTE_POS = g % WORD_BYTES;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                prefix_bytes_reg[g] <= 8'h00;
            end
            else if (cfg_write_en && (cfg_index == CFG_INDEX_W'(WORD_SEL)))
            begin
                prefix_bytes_reg[g] <= cfg_data[BYTE_POS*8 +: 8];
            end
        end
    end

    // Length register, reset to one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_length_reg <= LENGTH_W'(1);
        end
        else if (cfg_write_en && (cfg_index == REG_PREFIX_LENGTH))
        begin
            prefix_length_reg <= cfg_data[LENGTH_W-1:0];
        end
    end

    // A length of zero acts as one, and anything above the maximum is clamped.
    always_comb
    begin
        if (prefix_length_reg == '0)
        begin
            eff_length = LENGTH_W'(1);
        end
        else if (prefix_length_reg > LENGTH_W'(MAX_PREFIX))
        begin
            eff_length = LENGTH_W'(MAX_PREFIX);
        end
        else
        begin
            eff_length = prefix_length_reg;
        end
    end

    assign prefix_bytes = prefix_bytes_reg;

endmodule

// ===== rtl/ptpe_scanner.sv =====
// Scanner state and next-state logic of the path extractor.
// Matches the prefix, skips the first URL byte, and captures the path with one
// byte held back. Depends on ptpe_pkg.
module ptpe_scanner
    import ptpe_pkg::*;
#(
    parameter int MAX_PREFIX = PREFIX_MAX_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  in_item_t            item,
    input  logic [7:0]          prefix_bytes [MAX_PREFIX],
    input  logic [LENGTH_W-1:0] eff_length,
    output step_result_t        result
);

    localparam int IDX_W = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;

    logic [LENGTH_W-1:0] match_index_reg, match_index_next;
    logic [1:0]          phase_reg, phase_next;
    logic [7:0]          held_byte_reg, held_byte_next;
    logic [1:0]          captured_count_reg, captured_count_next;

    logic                is_url;
    logic [LENGTH_W-1:0] idx_base;
    logic [LENGTH_W-1:0] idx_inc;
    logic                run_match;

    assign is_url  = url_char(item.in_byte);

    // Next state and the result word of one step.
    always_comb
    begin
        match_index_next    = match_index_reg;
        phase_next          = phase_reg;
        held_byte_next      = held_byte_reg;
        captured_count_next = captured_count_reg;
        result.valid          = 1'b0;
        result.item.path_byte = held_byte_reg;
        result.item.path_last = 1'b0;
        run_match = 1'b0;
        idx_base  = match_index_reg;

        if (item.end_of_stream)
        begin
            // Close an open path and return to the reset state.
            if ((phase_reg == PH_CAPTURE) && captured_count_reg[1])
            begin
                result.valid          = 1'b1;
                result.item.path_last = 1'b1;
            end
            match_index_next    = '0;
            phase_next          = PH_MATCH;
            held_byte_next      = 8'h00;
            captured_count_next = CNT_NONE;
        end
        else if (phase_reg == PH_FIRST)
        begin
            // The byte after a full match is skipped but must be a URL byte.
            if (is_url)
            begin
                phase_next          = PH_CAPTURE;
                captured_count_next = CNT_NONE;
            end
            else
            begin
                phase_next       = PH_MATCH;
                match_index_next = '0;
            end
        end
        else if ((phase_reg == PH_CAPTURE) && is_url)
        begin
            // Emit the held byte once a newer one replaces it.
            if (captured_count_reg != CNT_NONE)
            begin
                result.valid        = 1'b1;
                captured_count_next = CNT_TWO;
            end
            else
            begin
                captured_count_next = CNT_ONE;
            end
            held_byte_next = item.in_byte;
        end
        else
        begin
            // A terminator ends the path and is then matched from zero.
            if (phase_reg == PH_CAPTURE)
            begin
                if (captured_count_reg[1])
                begin
                    result.valid          = 1'b1;
                    result.item.path_last = 1'b1;
                end
                held_byte_next      = 8'h00;
                captured_count_next = CNT_NONE;
                idx_base            = '0;
            end
            run_match = 1'b1;
        end

        idx_inc = idx_base + LENGTH_W'(1);

        // Prefix comparison, also for the unused phase code.
        if (run_match)
        begin
            phase_next = PH_MATCH;
            if (idx_base >= eff_length)
            begin
                // Length was lowered under a running match: treat as full.
                match_index_next = '0;
                if (is_url)
                begin
                    phase_next          = PH_CAPTURE;
                    captured_count_next = CNT_NONE;
                end
            end
            else if (item.in_byte == prefix_bytes[idx_base[IDX_W-1:0]])
            begin
                if (idx_inc >= eff_length)
                begin
                    phase_next       = PH_FIRST;
                    match_index_next = '0;
                end
                else
                begin
                    match_index_next = idx_inc;
                end
            end
            else
            begin
                match_index_next = '0;
            end
        end
    end

    // State registers advance once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_index_reg    <= '0;
            phase_reg          <= PH_MATCH;
            held_byte_reg      <= 8'h00;
            captured_count_reg <= CNT_NONE;
        end
        else if (step)
        begin
            match_index_reg    <= match_index_next;
            phase_reg          <= phase_next;
            held_byte_reg      <= held_byte_next;
            captured_count_reg <= captured_count_next;
        end
    end

    // A path byte only comes out of a capture that already holds a byte.
    a_emit_from_capture: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step && result.valid) |-> (phase_reg == PH_CAPTURE) && (captured_count_reg != CNT_NONE)
    ) else $error("path byte emitted outside a capture");

    // End of stream leaves the scanner in its reset state.
    a_eos_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step && item.end_of_stream) |=>
            (phase_reg == PH_MATCH) && (match_index_reg == '0) && (captured_count_reg == CNT_NONE)
    ) else $error("end of stream did not clear the scanner");

    // The skipped byte always restarts matching from zero.
    a_first_resets_index: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_FIRST)) |=> (match_index_reg == '0)
    ) else $error("match index not cleared after the skipped byte");

endmodule
